// ----- hw/rtl/bebq_pkg.sv -----
package bebq_pkg;

    localparam int DEFAULT_CAPACITY = 4096;
    localparam int BANKS            = 8;
    localparam int LANE_W           = $clog2(BANKS);

    localparam int OP_W     = 3;
    localparam int WCODE_W  = 2;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 12;
    localparam int DROP_W   = 13;
    localparam int FILL_W   = 13;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd1;
    localparam logic [OP_W-1:0] OP_CONSUME = 3'd2;
    localparam logic [OP_W-1:0] OP_DISCARD = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [WCODE_W-1:0]  width_code;
        logic [VALUE_W-1:0]  value_in;
        logic [OFFSET_W-1:0] byte_offset;
        logic [DROP_W-1:0]   drop_count;
        logic                sign_extend;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic               error;
        logic [FILL_W-1:0]  fill_level;
    } out_word_t;

endpackage

// ----- hw/rtl/bebq_ram.sv -----
module bebq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/big_endian_byte_queue.sv -----
// Append, discard, clear and rejected requests: result registered at the accepting edge.
// Peek and consume: all eight banks read on accept, in ST_READ the data is registered to m_data.
// Throughput: 1 word/cycle for append, discard, clear while m_ready allows; peek and consume
// block in ST_READ during the registered bank read. CAPACITY must be a multiple of 8.
// Reset: head and fill return to zero, output empty; byte banks are not cleared.
module big_endian_byte_queue
    import bebq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int ROWS = CAPACITY / BANKS;
    localparam int AW   = $clog2(CAPACITY);
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FW   = $clog2(CAPACITY + 1);
    localparam int CW   = ((FW > DROP_W) ? FW : DROP_W) + 1;
    localparam logic [CW-1:0] CAP_CW   = CW'(CAPACITY);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;
    logic [LANE_W-1:0]  rd_lo_reg, rd_lo_next;
    logic [WCODE_W-1:0] rd_code_reg, rd_code_next;
    logic               rd_sext_reg, rd_sext_next;

    logic               accept;
    logic               err;
    logic               rd_op;
    logic               wr_op;
    logic [3:0]         nbytes;
    logic [CW-1:0]      n_cw, fill_cw, head_cw, base_sum;
    logic [CW-1:0]      fill_ext;
    logic [AW-1:0]      base_addr, head_new;
    logic [FW-1:0]      fill_new;
    logic [LANE_W-1:0]  base_lo;
    logic [RW-1:0]      row0, row1;

    logic [LANE_W-1:0]  wr_idx  [BANKS];
    logic [LANE_W-1:0]  wr_lane [BANKS];
    logic [RW-1:0]      bank_row [BANKS];
    logic               bank_we [BANKS];
    logic [7:0]         bank_wdata [BANKS];
    logic               bank_re;
    logic [7:0]         bank_rdata [BANKS];

    logic [3:0]         rd_n;
    logic [LANE_W-1:0]  rd_sel [BANKS];
    logic               rd_sign;
    logic [VALUE_W-1:0] rd_value;

    function automatic logic [AW-1:0] wrap(input logic [CW-1:0] s);
        if (s >= CAP_CW) begin
            return AW'(s - CAP_CW);
        end
        return AW'(s);
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        nbytes   = 4'd1 << s_data.width_code;
        n_cw     = CW'(nbytes);
        fill_cw  = CW'(fill_reg);
        head_cw  = CW'(head_reg);
        err      = 1'b0;
        rd_op    = 1'b0;
        wr_op    = 1'b0;
        base_sum = head_cw;
        head_new = head_reg;
        fill_new = fill_reg;
        case (s_data.operation)
            OP_APPEND: begin
                err      = (fill_cw + n_cw) > CAP_CW;
                base_sum = head_cw + fill_cw;
                wr_op    = !err;
                fill_new = FW'(fill_cw + n_cw);
            end
            OP_PEEK: begin
                err      = (CW'(s_data.byte_offset) + n_cw) > fill_cw;
                base_sum = head_cw + CW'(s_data.byte_offset);
                rd_op    = !err;
            end
            OP_CONSUME: begin
                err      = n_cw > fill_cw;
                rd_op    = !err;
                head_new = wrap(head_cw + n_cw);
                fill_new = FW'(fill_cw - n_cw);
            end
            OP_DISCARD: begin
                err      = CW'(s_data.drop_count) > fill_cw;
                head_new = wrap(head_cw + CW'(s_data.drop_count));
                fill_new = FW'(fill_cw - CW'(s_data.drop_count));
            end
            OP_CLEAR: begin
                head_new = '0;
                fill_new = '0;
            end
            default: begin
            end
        endcase
        if (err) begin
            head_new = head_reg;
            fill_new = fill_reg;
        end
    end

    // bank b holds byte index (b - lo) of the access; wrapped bytes sit one row on
    always_comb begin
        base_addr = wrap(base_sum);
        base_lo   = base_addr[LANE_W-1:0];
        row0      = RW'(base_addr >> LANE_W);
        row1      = (row0 == LAST_ROW) ? '0 : row0 + RW'(1);
        bank_re   = accept && rd_op;
        for (int b = 0; b < BANKS; b++) begin
            wr_idx[b]     = LANE_W'(b) - base_lo;
            wr_lane[b]    = LANE_W'(nbytes - 4'd1 - {1'b0, wr_idx[b]});
            bank_row[b]   = (LANE_W'(b) >= base_lo) ? row0 : row1;
            bank_we[b]    = accept && wr_op && ({1'b0, wr_idx[b]} < nbytes);
            bank_wdata[b] = s_data.value_in[{wr_lane[b], 3'b000} +: 8];
        end
    end

    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        bebq_ram #(
            .WIDTH(8),
            .DEPTH(ROWS)
        ) u_ram (
            .aclk  (aclk),
            .we    (bank_we[g]),
            .waddr (bank_row[g]),
            .wdata (bank_wdata[g]),
            .re    (bank_re),
            .raddr (bank_row[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_comb begin
        rd_n     = 4'd1 << rd_code_reg;
        rd_sign  = rd_sext_reg && bank_rdata[rd_lo_reg][7];
        rd_value = '0;
        for (int k = 0; k < BANKS; k++) begin
            rd_sel[k] = rd_lo_reg + LANE_W'(rd_n - 4'd1 - 4'(k));
            if (4'(k) < rd_n) begin
                rd_value[k*8 +: 8] = bank_rdata[rd_sel[k]];
            end else if (rd_sign) begin
                rd_value[k*8 +: 8] = 8'hFF;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        rd_lo_next   = rd_lo_reg;
        rd_code_next = rd_code_reg;
        rd_sext_next = rd_sext_reg;
        fill_ext     = CW'(fill_new);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    head_next              = head_new;
                    fill_next              = fill_new;
                    m_data_next.value_out  = '0;
                    m_data_next.error      = err;
                    m_data_next.fill_level = fill_ext[FILL_W-1:0];
                    rd_lo_next             = base_lo;
                    rd_code_next           = s_data.width_code;
                    rd_sext_next           = s_data.sign_extend;
                    if (rd_op) begin
                        state_next = ST_READ;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                m_data_next.value_out = rd_value;
                m_valid_next          = 1'b1;
                state_next            = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg  <= m_data_next;
        rd_lo_reg   <= rd_lo_next;
        rd_code_reg <= rd_code_next;
        rd_sext_reg <= rd_sext_next;
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(fill_reg) <= CAP_CW)
        else $error("fill above capacity");

    a_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rd_op |=> state_reg == ST_READ && !m_valid_reg)
        else $error("bank read not followed by read cycle");

    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !s_ready && !bank_re)
        else $error("bank access during read cycle");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.operation == OP_CLEAR |=> fill_reg == '0 && head_reg == '0)
        else $error("clear left queue non-empty");

    a_err_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && err |=> $stable(fill_reg) && $stable(head_reg))
        else $error("rejected word changed queue state");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import bebq_pkg::*;
();

    localparam int CAP = DEFAULT_CAPACITY;

    localparam logic [WCODE_W-1:0] W_BYTE  = 2'd0;
    localparam logic [WCODE_W-1:0] W_HALF  = 2'd1;
    localparam logic [WCODE_W-1:0] W_WORD  = 2'd2;
    localparam logic [WCODE_W-1:0] W_DWORD = 2'd3;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_CLEAR + 1'b1;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    big_endian_byte_queue u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // shadow copy of the queue
    logic [7:0] mirror_bytes [CAP];
    int         mirror_head = 0;
    int         mirror_fill = 0;

    out_word_t  pending_replies [$];
    int         mismatch_count = 0;
    bit         gaps_on   = 1'b1;
    bit         stalls_on = 1'b1;

    function automatic logic [VALUE_W-1:0] read_big_endian(int off, int n, bit sx);
        logic [VALUE_W-1:0] v;
        int i;
        v = '0;
        for (i = 0; i < n; i++) begin
            v = {v[VALUE_W-9:0], mirror_bytes[(mirror_head + off + i) % CAP]};
        end
        if (sx && n < 8 && v[8*n-1]) begin
            v = v | ({VALUE_W{1'b1}} << (8 * n));
        end
        return v;
    endfunction

    function automatic out_word_t byte_queue_reply(in_word_t w);
        out_word_t r;
        int n;
        int i;
        r = '0;
        n = 1 << w.width_code;
        case (w.operation)
            OP_APPEND: begin
                if (mirror_fill + n > CAP) begin
                    r.error = 1'b1;
                end else begin
                    for (i = 0; i < n; i++) begin
                        mirror_bytes[(mirror_head + mirror_fill + i) % CAP] =
                            w.value_in[8*(n-1-i) +: 8];
                    end
                    mirror_fill += n;
                end
            end
            OP_PEEK: begin
                if (int'(w.byte_offset) + n > mirror_fill) begin
                    r.error = 1'b1;
                end else begin
                    r.value_out = read_big_endian(int'(w.byte_offset), n, w.sign_extend);
                end
            end
            OP_CONSUME: begin
                if (n > mirror_fill) begin
                    r.error = 1'b1;
                end else begin
                    r.value_out = read_big_endian(0, n, w.sign_extend);
                    mirror_head = (mirror_head + n) % CAP;
                    mirror_fill -= n;
                end
            end
            OP_DISCARD: begin
                if (int'(w.drop_count) > mirror_fill) begin
                    r.error = 1'b1;
                end else begin
                    mirror_head = (mirror_head + int'(w.drop_count)) % CAP;
                    mirror_fill -= int'(w.drop_count);
                end
            end
            OP_CLEAR: begin
                mirror_head = 0;
                mirror_fill = 0;
            end
            default: begin
            end
        endcase
        r.fill_level = FILL_W'(mirror_fill);
        return r;
    endfunction

    function automatic in_word_t make_request(logic [OP_W-1:0] op, logic [WCODE_W-1:0] wc,
                                              logic [VALUE_W-1:0] val, int off, int drop,
                                              bit sx);
        in_word_t w;
        w.operation   = op;
        w.width_code  = wc;
        w.value_in    = val;
        w.byte_offset = OFFSET_W'(off);
        w.drop_count  = DROP_W'(drop);
        w.sign_extend = sx;
        return w;
    endfunction

    function automatic in_word_t random_request(bit grow);
        in_word_t w;
        int r;
        int span;
        w.value_in    = {$urandom, $urandom};
        w.width_code  = WCODE_W'($urandom);
        w.byte_offset = OFFSET_W'($urandom);
        w.drop_count  = DROP_W'($urandom);
        w.sign_extend = 1'($urandom);
        w.operation   = OP_W'($urandom);
        r = $urandom_range(99, 0);
        if (r < (grow ? 60 : 25)) begin
            w.operation = OP_APPEND;
        end else begin
            r = $urandom_range(99, 0);
            if (r < 35) begin
                w.operation = OP_PEEK;
                span = (mirror_fill > CAP - 1) ? CAP - 1 : mirror_fill;
                if ($urandom_range(9, 0) < 8) w.byte_offset = OFFSET_W'($urandom_range(span, 0));
            end else if (r < 70) begin
                w.operation = OP_CONSUME;
            end else if (r < 90) begin
                w.operation = OP_DISCARD;
                span = (mirror_fill < 24) ? mirror_fill + 1 : 24;
                if ($urandom_range(9, 0) < 8) w.drop_count = DROP_W'($urandom_range(span, 0));
            end else if (r < 93) begin
                w.operation = OP_CLEAR;
            end else if (r < 97) begin
                w.operation = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            end
        end
        return w;
    endfunction

    task automatic pause_sender();
        int r;
        int g;
        g = 0;
        if (gaps_on) begin
            r = $urandom_range(99, 0);
            if (r >= 90) g = $urandom_range(40, 8);
            else if (r >= 55) g = $urandom_range(3, 1);
        end
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send_request(input in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        pending_replies.insert(pending_replies.size(), byte_queue_reply(w));
        pause_sender();
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_replies.size() != 0);
    endtask

    task automatic check_reply(input out_word_t got);
        out_word_t want;
        bit bad;
        bad = 1'b0;
        if (pending_replies.size() == 0) begin
            $display("%0t: word with none pending, expected nothing, actual %h", $time, got);
            mismatch_count++;
        end else begin
            want = pending_replies.pop_front();
            if (got.value_out !== want.value_out) begin
                $display("%0t: value_out expected %h, actual %h",
                         $time, want.value_out, got.value_out);
                bad = 1'b1;
            end
            if (got.error !== want.error) begin
                $display("%0t: error expected %b, actual %b", $time, want.error, got.error);
                bad = 1'b1;
            end
            if (got.fill_level !== want.fill_level) begin
                $display("%0t: fill_level expected %0d, actual %0d",
                         $time, want.fill_level, got.fill_level);
                bad = 1'b1;
            end
            if (bad) mismatch_count++;
        end
    endtask

    // m_data is stable from the falling edge until the transfer edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) check_reply(m_data);
    end

    initial begin : result_backpressure
        int r;
        int n;
        @(posedge aclk);
        forever begin
            if (!stalls_on) begin
                m_ready <= 1'b1;
                n = 1;
            end else begin
                r = $urandom_range(99, 0);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    n = $urandom_range(16, 1);
                end else if (r < 92) begin
                    m_ready <= 1'b0;
                    n = $urandom_range(3, 1);
                end else begin
                    m_ready <= 1'b0;
                    n = $urandom_range(30, 10);
                end
            end
            repeat (n) @(posedge aclk);
        end
    end

    task automatic test_directed_ops();
        int op;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        send_request(make_request(OP_CONSUME, W_BYTE, '0, 0, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_BYTE, '0, 0, 0, 1'b0));
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, 1, 1'b0));
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, 0, 1'b0));
        send_request(make_request(OP_APPEND, W_BYTE, 64'hA5A5_A5A5_A5A5_A580, 0, 0, 1'b0));
        send_request(make_request(OP_APPEND, W_HALF, 64'h5A5A_0000_0000_8001, 0, 0, 1'b0));
        send_request(make_request(OP_APPEND, W_WORD, 64'h1234_5678_DEAD_BEEF, 0, 0, 1'b0));
        send_request(make_request(OP_APPEND, W_DWORD, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_BYTE, '0, 0, 0, 1'b1));
        send_request(make_request(OP_PEEK, W_HALF, '0, 1, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_WORD, '0, 3, 0, 1'b1));
        send_request(make_request(OP_PEEK, W_DWORD, '0, 7, 0, 1'b1));
        send_request(make_request(OP_PEEK, W_DWORD, '0, 8, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_BYTE, '0, CAP - 1, 0, 1'b1));
        send_request(make_request(OP_CONSUME, W_BYTE, '0, 0, 0, 1'b1));
        send_request(make_request(OP_CONSUME, W_HALF, '0, 0, 0, 1'b1));
        send_request(make_request(OP_CONSUME, W_WORD, '0, 0, 0, 1'b0));
        send_request(make_request(OP_CONSUME, W_DWORD, '0, 0, 0, 1'b1));
        send_request(make_request(OP_APPEND, W_HALF, 64'h0000_0000_0000_7FFF, 0, 0, 1'b0));
        send_request(make_request(OP_CONSUME, W_HALF, '0, 0, 0, 1'b1));
        for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            send_request(make_request(OP_W'(op), W_DWORD, {VALUE_W{1'b1}}, CAP - 1,
                                      (1 << DROP_W) - 1, 1'b1));
        end
        send_request(make_request(OP_APPEND, W_BYTE, 64'h12, 0, 0, 1'b0));
        send_request(make_request(OP_CLEAR, W_BYTE, '0, 0, 0, 1'b0));
        send_request(make_request(OP_CONSUME, W_BYTE, '0, 0, 0, 1'b0));
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, (1 << DROP_W) - 1, 1'b0));
    endtask

    // head moved off zero first so the full queue wraps the store
    task automatic test_capacity_edges();
        int k;
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        send_request(make_request(OP_CLEAR, W_BYTE, '0, 0, 0, 1'b0));
        for (k = 0; k < 3; k++) begin
            send_request(make_request(OP_APPEND, W_BYTE, {$urandom, $urandom}, 0, 0, 1'b0));
        end
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, 3, 1'b0));
        for (k = 0; k < CAP / 8; k++) begin
            send_request(make_request(OP_APPEND, W_DWORD, {$urandom, $urandom}, 0, 0, 1'b0));
        end
        send_request(make_request(OP_APPEND, W_BYTE, {$urandom, $urandom}, 0, 0, 1'b0));
        send_request(make_request(OP_APPEND, W_DWORD, {$urandom, $urandom}, 0, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_DWORD, '0, CAP - 8, 0, 1'b1));
        send_request(make_request(OP_PEEK, W_DWORD, '0, CAP - 7, 0, 1'b0));
        send_request(make_request(OP_PEEK, W_BYTE, '0, CAP - 1, 0, 1'b1));
        send_request(make_request(OP_CONSUME, W_WORD, '0, 0, 0, 1'b1));
        send_request(make_request(OP_APPEND, W_WORD, {$urandom, $urandom}, 0, 0, 1'b0));
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, CAP + 1, 1'b0));
        send_request(make_request(OP_DISCARD, W_BYTE, '0, 0, CAP, 1'b0));
        gaps_on = 1'b1;
    endtask

    // alternating fill and drain phases, first stretch at full rate
    task automatic test_random_traffic();
        int k;
        bit grow;
        grow      = 1'b1;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        for (k = 0; k < 450; k++) begin
            if (k == 60) begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end
            if (k % 75 == 74) begin
                grow = !grow;
                drain_replies();
            end
            send_request(random_request(grow));
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        drain_replies();
        test_capacity_edges();
        drain_replies();
        test_random_traffic();
        drain_replies();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bebq_pkg.sv
hw/rtl/bebq_ram.sv
hw/rtl/big_endian_byte_queue.sv
dv/testbench.sv
